FILE: sv/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types, sizes and request codes of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int RANK_W     = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CFG_W      = 5;
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NOTFOUND = 1'b1;

    typedef logic [ENTRIES-1:0]    t_slot_vec;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [RANK_W-1:0]     t_rank;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic                  status;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
        logic [VALUE_BITS-1:0] evicted_value;
        logic [CNT_W-1:0]      entry_count;
    } t_result;

    typedef struct packed {
        logic hit;
        t_idx idx;
    } t_match;

    // Lowest set bit of a slot vector; zero when none is set.
    function automatic t_idx first_idx(input t_slot_vec v);
        t_idx r;
        r = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = t_idx'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/lkv_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_match
// Compares the request key with every valid slot in parallel.
// ----------------------------------------------------------------------------
module lkv_match (
    input  lkv_pkg::t_key      i_key,
    input  lkv_pkg::t_slot_vec i_slot_valid,
    input  lkv_pkg::t_key      i_slot_key [lkv_pkg::ENTRIES],
    output lkv_pkg::t_match    o_match
);
    import lkv_pkg::*;

    t_slot_vec hit_vec;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = i_slot_valid[i] && (i_slot_key[i] == i_key);
        end
        o_match.hit = |hit_vec;
        o_match.idx = first_idx(hit_vec);
    end

endmodule
`default_nettype wire

FILE: sv/lkv_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_store
// Slot state (valid, key, value, recency rank, count) and its update for
// one request per cycle. Rank 0 is the most recently used slot.
// ----------------------------------------------------------------------------
module lkv_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                    i_valid,
    input  lkv_pkg::t_req           i_req,
    input  lkv_pkg::t_match         i_match,
    output lkv_pkg::t_slot_vec      o_slot_valid,
    output lkv_pkg::t_key           o_slot_key [lkv_pkg::ENTRIES],
    output lkv_pkg::t_result        o_result
);
    import lkv_pkg::*;

    logic [CFG_W-1:0] r_max_entries;
    t_slot_vec        r_valid;
    t_key             r_key   [ENTRIES];
    t_value           r_value [ENTRIES];
    t_rank            r_rank  [ENTRIES];
    t_count           r_count;

    t_slot_vec n_valid;
    t_rank     n_rank [ENTRIES];
    t_count    n_count;
    logic      n_wr_en;
    t_idx      n_wr_idx;

    t_count    cap;
    logic      is_set, is_get, is_rem, drop;
    t_rank     hit_rank;
    t_slot_vec drop_oh, valid1, valid2, lru_vec, evict_oh;
    t_rank     rank1 [ENTRIES];
    t_count    count1, count2, lru_rank;
    logic      evict;
    t_idx      lru_idx, free_idx, rd_idx;

    assign o_slot_valid = r_valid;
    assign o_slot_key   = r_key;

    always_comb begin
        // Capacity in use, clamped to 1..ENTRIES
        if (r_max_entries == '0) begin
            cap = t_count'(1);
        end else if (int'(r_max_entries) > ENTRIES) begin
            cap = t_count'(ENTRIES);
        end else begin
            cap = t_count'(r_max_entries);
        end

        is_set   = (i_req.req_type == REQ_SET);
        is_get   = (i_req.req_type == REQ_GET);
        is_rem   = (i_req.req_type == REQ_REMOVE);
        hit_rank = r_rank[i_match.idx];

        // Drop of the matching slot (set and remove)
        drop    = i_match.hit && (is_set || is_rem);
        drop_oh = drop ? (t_slot_vec'(1) << i_match.idx) : '0;
        valid1  = r_valid & ~drop_oh;
        count1  = r_count - t_count'(drop);
        for (int i = 0; i < ENTRIES; i++) begin
            rank1[i] = (drop && r_valid[i] && r_rank[i] > hit_rank)
                       ? r_rank[i] - t_rank'(1) : r_rank[i];
        end

        // LRU eviction when the set would overflow the capacity
        lru_rank = count1 - t_count'(1);
        for (int i = 0; i < ENTRIES; i++) begin
            lru_vec[i] = valid1[i] && (t_count'(rank1[i]) == lru_rank);
        end
        lru_idx  = first_idx(lru_vec);
        evict    = is_set && (count1 >= cap) && (|lru_vec);
        evict_oh = evict ? (t_slot_vec'(1) << lru_idx) : '0;
        valid2   = valid1 & ~evict_oh;
        count2   = count1 - t_count'(evict);
        free_idx = first_idx(~valid2);

        n_valid  = r_valid;
        n_count  = r_count;
        n_wr_en  = 1'b0;
        n_wr_idx = free_idx;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end

        if (is_set) begin
            n_valid = valid2 | (t_slot_vec'(1) << free_idx);
            n_count = count2 + t_count'(1);
            n_wr_en = 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
                n_rank[i] = valid2[i] ? rank1[i] + t_rank'(1) : '0;
            end
        end else if (is_get && i_match.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                n_rank[i] = (r_valid[i] && r_rank[i] < hit_rank)
                            ? r_rank[i] + t_rank'(1) : r_rank[i];
            end
            n_rank[i_match.idx] = '0;
        end else if (is_rem && i_match.hit) begin
            n_valid = valid1;
            n_count = count1;
            for (int i = 0; i < ENTRIES; i++) begin
                n_rank[i] = rank1[i];
            end
        end

        // One value read per request: the hit slot, or the LRU slot on a set
        rd_idx = is_set ? lru_idx : i_match.idx;

        o_result.status        = ((is_get || is_rem) && !i_match.hit)
                                 ? STATUS_NOTFOUND : STATUS_OK;
        o_result.read_value    = (is_get && i_match.hit) ? r_value[rd_idx] : '0;
        o_result.evicted       = evict;
        o_result.evicted_key   = evict ? r_key[lru_idx] : '0;
        o_result.evicted_value = evict ? r_value[rd_idx] : '0;
        o_result.entry_count   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= CFG_W'(ENTRIES);
            r_valid       <= '0;
            r_count       <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
            if (i_valid) begin
                r_valid <= n_valid;
                r_count <= n_count;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    // Slot payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && n_wr_en) begin
            r_key[n_wr_idx]   <= i_req.key;
            r_value[n_wr_idx] <= i_req.value;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache, 16 slots, least-recently-used eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req (req_type, key, value) and raise start.
//   A beat is taken at each rising edge with start high and busy low.
//   busy is low whenever reset is released, so one beat per cycle.
//   Result channel: o_result is shown for exactly one cycle with
//   o_result_valid high; the receiver cannot stall it. Results come out
//   in request order, one per request.
//   A taken request is held in the request register, processed by
//   the match/update logic, and its result is captured in the result
//   register that drives o_result. Throughput is one request per cycle: the
//   key match over all slots and the rank update are one combinational
//   pass between the request register and the result register.
//   Config: i_cfg_we/i_cfg_wdata write max_entries (0 acts as 1, values
//   above 16 act as 16). Write only while no request is in flight.
//   Reset (synchronous, active low): all slots invalid, count zero,
//   max_entries 16; busy is high while reset is held.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lkv_pkg::t_req             i_req,
    output logic                      o_result_valid,
    output lkv_pkg::t_result          o_result,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0] i_cfg_wdata
);
    import lkv_pkg::*;

    // Request register
    logic      r_req_valid;
    t_req      r_req;
    // Result register
    logic      r_out_valid;
    t_result   r_result;

    t_match    match;
    t_slot_vec slot_valid;
    t_key      slot_key [ENTRIES];
    t_result   result;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req_valid <= start;
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (r_req_valid) begin
            r_result <= result;
        end
    end

    // Parallel key compare against all valid slots
    lkv_match u_match (
        .i_key        (r_req.key),
        .i_slot_valid (slot_valid),
        .i_slot_key   (slot_key),
        .o_match      (match)
    );

    // Slot state, LRU ranks, eviction and result fields
    lkv_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (r_req_valid),
        .i_req        (r_req),
        .i_match      (match),
        .o_slot_valid (slot_valid),
        .o_slot_key   (slot_key),
        .o_result     (result)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

endmodule
`default_nettype wire

FILE: sv/lkv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input lkv_pkg::t_req             i_req,
    input logic                      o_result_valid,
    input lkv_pkg::t_result          o_result,
    input logic                      i_cfg_we,
    input logic [lkv_pkg::CFG_W-1:0] i_cfg_wdata
);
    import lkv_pkg::*;

    // Every accepted beat yields a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("missing result for accepted request");

    // No result without an earlier accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result without request");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.entry_count <= CNT_W'(ENTRIES)))
        else $error("entry count out of range");

    // A miss returns no data and never evicts
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == STATUS_NOTFOUND) |->
        (o_result.read_value == '0 && !o_result.evicted))
        else $error("miss carries data or eviction");

    // An eviction only happens on a set, which always leaves an entry
    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.evicted) |->
        (o_result.entry_count != '0 && o_result.status == STATUS_OK))
        else $error("eviction with empty cache");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
`default_nettype wire
